@@ hdl/tspcr_pkg.sv @@
// Shared types and constants of the PCR interpolator.
// Used by every module under hdl; depends on nothing.
package tspcr_pkg;

	localparam int unsigned PCR_W   = 42;
	localparam int unsigned CNT_W   = 6;
	localparam int unsigned BURST_W = 7;
	localparam logic [PCR_W-1:0] CLOCK_MOD = 42'd2576980377600;
	localparam int unsigned MAX_PENDING_DEF = 63;

	// One release burst handed from the front to the back.
	typedef struct packed {
		logic [BURST_W-1:0] cnt;
		logic [PCR_W-1:0]   base;
		logic [PCR_W-1:0]   delta;
		logic [CNT_W-1:0]   span;
		logic               interp;
		logic               first_known;
		logic               ovf;
	} job_t;

endpackage

@@ hdl/tspcr_front.sv @@
// Front end: accepts packet words, tracks the anchor and pending count,
// and turns each word into at most one release job. Depends on tspcr_pkg.
module tspcr_front import tspcr_pkg::*; #(
	parameter int unsigned MAX_PENDING = MAX_PENDING_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic             command,
	input  logic             has_pcr,
	input  logic [PCR_W-1:0] pcr_value,
	output logic             push,
	output job_t             job
);

	logic [PCR_W-1:0] prev_q, last_delta_q, delta;
	logic [CNT_W-1:0] pend_q, last_span_q;
	logic             have_q, rate_q, pcr_ok;
	logic [PCR_W:0]   diff;

	assign pcr_ok = has_pcr && (pcr_value < CLOCK_MOD);
	assign diff   = (pcr_value > prev_q) ? ({1'b0, pcr_value} - {1'b0, prev_q})
	                : ({1'b0, pcr_value} + {1'b0, CLOCK_MOD} - {1'b0, prev_q});
	assign delta  = diff[PCR_W-1:0];

	always_comb begin
		push = 1'b0;
		job  = '0;
		job.base = prev_q;
		if (command) begin
			push = take && (pend_q != '0);
			job.cnt = {1'b0, pend_q};
			job.first_known = 1'b1;
			job.interp = rate_q && (last_span_q != '0);
			job.delta = last_delta_q;
			job.span = last_span_q;
		end else if (pcr_ok) begin
			push = take && have_q;
			job.cnt = {1'b0, pend_q};
			job.first_known = 1'b1;
			job.interp = 1'b1;
			job.delta = delta;
			job.span = pend_q;
		end else if (!have_q) begin
			push = take;
			job.cnt = BURST_W'(1);
		end else if (pend_q == CNT_W'(MAX_PENDING)) begin
			push = take;
			job.cnt = {1'b0, pend_q} + BURST_W'(1);
			job.ovf = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			have_q <= 1'b0;
			pend_q <= '0;
			last_delta_q <= '0;
			last_span_q <= '0;
			rate_q <= 1'b0;
		end else if (take) begin
			if (command) begin
				pend_q <= '0;
				have_q <= 1'b0;
			end else if (pcr_ok) begin
				if (have_q) begin
					last_delta_q <= delta;
					last_span_q <= pend_q;
					rate_q <= 1'b1;
				end
				prev_q <= pcr_value;
				have_q <= 1'b1;
				pend_q <= CNT_W'(1);
			end else if (have_q) begin
				if (pend_q == CNT_W'(MAX_PENDING)) begin
					pend_q <= '0;
					have_q <= 1'b0;
				end else begin
					pend_q <= pend_q + CNT_W'(1);
				end
			end
		end
	end

endmodule

@@ hdl/tspcr_fifo.sv @@
// Two-entry job queue between front and back.
// Depends on tspcr_pkg for the job type.
module tspcr_fifo import tspcr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wdata,
	input  logic pop,
	output job_t rdata,
	output logic nonempty,
	output logic full
);

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign rdata    = mem_q[rp_q];
	assign nonempty = (cnt_q != 2'd0);
	assign full     = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

@@ hdl/tspcr_back.sv @@
// Back end: divides the interval once per interpolated job, then steps
// through held packets, one word per unstalled cycle. Needs tspcr_pkg.
module tspcr_back import tspcr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  job_t             job,
	input  logic             job_valid,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PCR_W-1:0] pcr_interp,
	output logic             pcr_known,
	output logic             overflow,
	output logic             last
);

	typedef enum logic [1:0] {IDLE, DIV, FIX, EMIT} state_t;

	localparam int unsigned DIV_STEPS = (PCR_W + 2) / 3;

	state_t             state_q;
	job_t               job_q;
	logic [PCR_W-1:0]   dd_q, acc_q;
	logic [CNT_W-1:0]   rem_q, r_q;
	logic [3:0]         it_q;
	logic [BURST_W-1:0] k_q;
	logic               par_q;
	logic               ov_q, known_q, ovf_q, last_q;
	logic [PCR_W-1:0]   val_q;

	// Three restoring division steps per cycle on a narrow remainder.
	logic [CNT_W:0]   tr [4];
	logic [PCR_W-1:0] td [4];
	always_comb begin
		tr[0] = {1'b0, rem_q};
		td[0] = dd_q;
		for (int i = 0; i < 3; i++) begin
			tr[i+1] = {tr[i][CNT_W-1:0], td[i][PCR_W-1]};
			td[i+1] = {td[i][PCR_W-2:0], 1'b0};
			if (tr[i+1] >= {1'b0, job_q.span}) begin
				tr[i+1] = tr[i+1] - {1'b0, job_q.span};
				td[i+1][0] = 1'b1;
			end
		end
	end

	// Stepping: acc tracks prev + floor(k*delta/span) mod CLOCK_MOD.
	logic [CNT_W:0]   rsum, r2;
	logic             carry, rnd;
	logic [PCR_W:0]   asum, osum;
	logic [PCR_W-1:0] acc_nx, out_val;
	always_comb begin
		rsum  = {1'b0, r_q} + {1'b0, rem_q};
		carry = (rsum >= {1'b0, job_q.span});
		r2    = carry ? rsum - {1'b0, job_q.span} : rsum;
		asum  = {1'b0, acc_q} + {1'b0, dd_q} + {{PCR_W{1'b0}}, carry};
		acc_nx = (asum >= {1'b0, CLOCK_MOD}) ? PCR_W'(asum - {1'b0, CLOCK_MOD})
		         : asum[PCR_W-1:0];
		rnd   = ({r_q, 1'b0} > {1'b0, job_q.span})
		        || (({r_q, 1'b0} == {1'b0, job_q.span}) && par_q);
		osum  = {1'b0, acc_q} + {{PCR_W{1'b0}}, rnd};
		out_val = (osum >= {1'b0, CLOCK_MOD}) ? PCR_W'(osum - {1'b0, CLOCK_MOD})
		          : osum[PCR_W-1:0];
	end

	logic k_known, k_last, can_out, emit;
	assign k_known = (k_q == '0) ? job_q.first_known : job_q.interp;
	assign k_last  = (k_q == job_q.cnt - BURST_W'(1));
	assign can_out = !ov_q || !out_stall;
	assign emit    = (state_q == EMIT) && can_out;
	assign pop     = (state_q == IDLE) && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ov_q <= 1'b0;
			job_q <= '0;
			dd_q <= '0;
			acc_q <= '0;
			rem_q <= '0;
			r_q <= '0;
			it_q <= '0;
			k_q <= '0;
			par_q <= 1'b0;
			known_q <= 1'b0;
			ovf_q <= 1'b0;
			last_q <= 1'b0;
			val_q <= '0;
		end else begin
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (job_valid) begin
						job_q <= job;
						dd_q <= job.delta;
						rem_q <= '0;
						it_q <= '0;
						acc_q <= job.base;
						r_q <= '0;
						par_q <= 1'b0;
						k_q <= '0;
						state_q <= (job.interp && job.cnt > BURST_W'(1)) ? DIV : EMIT;
					end
				end
				DIV: begin
					dd_q <= td[3];
					rem_q <= tr[3][CNT_W-1:0];
					it_q <= it_q + 4'd1;
					if (it_q == 4'(DIV_STEPS - 1)) state_q <= FIX;
				end
				FIX: begin
					if (dd_q >= CLOCK_MOD) dd_q <= dd_q - CLOCK_MOD;
					state_q <= EMIT;
				end
				EMIT: begin
					if (can_out) begin
						known_q <= k_known;
						ovf_q <= job_q.ovf;
						last_q <= k_last;
						val_q <= k_known ? out_val : '0;
						k_q <= k_q + BURST_W'(1);
						r_q <= r2[CNT_W-1:0];
						acc_q <= acc_nx;
						par_q <= par_q ^ dd_q[0] ^ carry;
						if (k_last) state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign out_valid  = ov_q;
	assign pcr_interp = val_q;
	assign pcr_known  = known_q;
	assign overflow   = ovf_q;
	assign last       = last_q;

endmodule

@@ hdl/ts_pcr_interpolator_top.sv @@
// Top level of the PCR interpolator: front end, job queue, back end.
// Depends on tspcr_pkg, tspcr_front, tspcr_fifo and tspcr_back.
//
// Usage. The input channel (in_valid/in_stall) takes one word per packet
// event: command 0 is a packet, optionally with a PCR, command 1 flushes the
// held packets. The output channel (out_valid/out_stall) returns one word
// per released packet in arrival order, with last set on the final word of
// each burst.
// Throughput. A packet that releases a burst queues one job; the back end
// then divides the interval by the packet count (three quotient bits per
// cycle over 42 bits, then a modulo reduction step) and afterwards issues
// one result word per cycle while out_stall is low. Jobs that need no
// interpolation skip the division.
// The two-entry job queue lets the front take new packets while the back
// is busy; in_stall rises only when both entries hold jobs.
// Reset clears the anchor, pending count and interval history, empties the
// queue and drops any result word not yet taken.
// A valid result word holds while out_stall is high; the back end waits.
module ts_pcr_interpolator_top import tspcr_pkg::*; #(
	parameter int unsigned MAX_PENDING = MAX_PENDING_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             command,
	input  logic             has_pcr,
	input  logic [PCR_W-1:0] pcr_value,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [PCR_W-1:0] pcr_interp,
	output logic             pcr_known,
	output logic             overflow,
	output logic             last
);

	logic take, push, pop, job_valid, full;
	job_t fjob, bjob;

	// A word is taken whenever the queue has room for the job it may create.
	assign in_stall = full;
	assign take     = in_valid && !full;

	tspcr_front #(.MAX_PENDING(MAX_PENDING)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .command(command),
		.has_pcr(has_pcr), .pcr_value(pcr_value), .push(push), .job(fjob)
	);

	tspcr_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(fjob), .pop(pop),
		.rdata(bjob), .nonempty(job_valid), .full(full)
	);

	tspcr_back u_back (
		.clk(clk), .arst_n(arst_n), .job(bjob), .job_valid(job_valid), .pop(pop),
		.out_valid(out_valid), .out_stall(out_stall), .pcr_interp(pcr_interp),
		.pcr_known(pcr_known), .overflow(overflow), .last(last)
	);

	// Untimed words always carry a zero clock.
	a_untimed_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pcr_known |-> pcr_interp == '0)
		else $error("untimed word with nonzero clock");

	// Overflow releases are never timed.
	a_ovf_untimed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> !pcr_known)
		else $error("overflow word marked timed");

	// The input side only stalls when jobs are waiting.
	a_stall_has_jobs: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> job_valid)
		else $error("stall with empty queue");

endmodule
